[rtl/pmd_pkg.sv]
// ============================================================================
// pmd_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ============================================================================
package pmd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NUM_BTN  = 3;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned BTN_W    = 2;
    localparam int unsigned DX_W     = 8;
    localparam int unsigned DY_W     = 9;
    localparam int unsigned POS_W    = 2;
    localparam int unsigned PEND_W   = NUM_BTN + 1;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_MOVE = 2'd0;
    localparam logic [KIND_W-1:0] EV_DOWN = 2'd1;
    localparam logic [KIND_W-1:0] EV_UP   = 2'd2;

    // Byte positions inside a packet
    localparam logic [POS_W-1:0] POS_FIRST = 2'd0;
    localparam logic [POS_W-1:0] POS_LAST  = 2'd2;
    localparam logic [POS_W-1:0] POS_BAD   = 2'd3;

    // One completed packet that causes at least one event
    typedef struct packed {
        logic [BYTE_W-1:0]  dx_byte;
        logic [BYTE_W-1:0]  dy_byte;
        logic               has_move;
        logic [NUM_BTN-1:0] changed;
        logic [NUM_BTN-1:0] old_buttons;
    } t_job;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic can_push;
        logic can_pop;
    } t_q_stat;

endpackage

[rtl/pmd_in_if.sv]
// ============================================================================
// pmd_in_if
// Input channel: one controller byte with its flags per beat.
// ============================================================================
interface pmd_in_if;
    logic       valid;
    logic       ready;
    logic       aux_ready;
    logic [7:0] data_byte;
    logic       listener_present;

    modport source (output valid, aux_ready, data_byte, listener_present, input ready);
    modport sink   (input valid, aux_ready, data_byte, listener_present, output ready);
endinterface

[rtl/pmd_out_if.sv]
// ============================================================================
// pmd_out_if
// Output channel: one mouse event per beat.
// ============================================================================
interface pmd_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic signed [7:0] delta_x;
    logic signed [8:0] delta_y;
    logic [1:0]        button_number;
    logic              last_event;

    modport source (output valid, event_kind, delta_x, delta_y, button_number, last_event,
                    input ready);
    modport sink   (input valid, event_kind, delta_x, delta_y, button_number, last_event,
                    output ready);
endinterface

[rtl/pmd_front.sv]
// ============================================================================
// pmd_front
// Accepts controller bytes, assembles packets and queues event jobs.
// ============================================================================
module pmd_front
    import pmd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    pmd_in_if.sink  i_in,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_job    o_job
);

    // Only bytes 0 and 1 are ever read back; byte 2 completes the packet
    // and is taken straight from the beat.
    logic [BYTE_W-1:0]  r_byte0, n_byte0;
    logic [BYTE_W-1:0]  r_byte1, n_byte1;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [NUM_BTN-1:0] r_buttons, n_buttons;

    logic               accept;
    logic [POS_W-1:0]   pos_eff;
    logic               complete;
    logic [NUM_BTN-1:0] changed;
    logic               has_move;

    assign i_in.ready = i_q_stat.can_push;
    assign accept     = i_in.valid && i_in.ready && i_in.aux_ready;
    assign pos_eff    = (r_pos == POS_BAD) ? POS_FIRST : r_pos;
    assign complete   = accept && i_in.listener_present && (pos_eff == POS_LAST);
    assign changed    = r_byte0[NUM_BTN-1:0] ^ r_buttons;
    assign has_move   = (r_byte1 != '0) || (i_in.data_byte != '0);

    always_comb begin
        n_byte0   = r_byte0;
        n_byte1   = r_byte1;
        n_pos     = r_pos;
        n_buttons = r_buttons;
        if (accept) begin
            case (pos_eff)
                2'd0:    n_byte0 = i_in.data_byte;
                2'd1:    n_byte1 = i_in.data_byte;
                default: ;
            endcase
            if (i_in.listener_present) begin
                n_pos = (pos_eff == POS_LAST) ? POS_FIRST : pos_eff + 2'd1;
            end else begin
                n_pos = pos_eff;
            end
        end
        if (complete) begin
            n_buttons = r_byte0[NUM_BTN-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte0   <= '0;
            r_byte1   <= '0;
            r_pos     <= POS_LAST;
            r_buttons <= '0;
        end else begin
            r_byte0   <= n_byte0;
            r_byte1   <= n_byte1;
            r_pos     <= n_pos;
            r_buttons <= n_buttons;
        end
    end

    // Drop empty packets here so the back part only sees real work.
    assign o_push            = complete && (has_move || (changed != '0));
    assign o_job.dx_byte     = r_byte1;
    assign o_job.dy_byte     = i_in.data_byte;
    assign o_job.has_move    = has_move;
    assign o_job.changed     = changed;
    assign o_job.old_buttons = r_buttons;

endmodule

[rtl/pmd_job_fifo.sv]
// ============================================================================
// pmd_job_fifo
// Short register queue of event jobs between front and back parts.
// ============================================================================
module pmd_job_fifo
    import pmd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.can_push = (r_count != FULL_CNT);
    assign o_stat.can_pop  = (r_count != '0);
    assign do_push         = i_push && o_stat.can_push;
    assign do_pop          = i_pop && o_stat.can_pop;
    assign o_job           = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[rtl/pmd_back.sv]
// ============================================================================
// pmd_back
// Expands queued jobs into move and button events, one per cycle while the sink is ready.
// ============================================================================
module pmd_back
    import pmd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_q_stat  i_q_stat,
    input  t_job     i_job,
    output logic     o_pop,
    pmd_out_if.source o_out
);

    // Pending bits: [0] move, [1..3] buttons 1..3
    logic [PEND_W-1:0]  r_pending, n_pending;
    logic [BYTE_W-1:0]  r_dx_byte;
    logic [BYTE_W-1:0]  r_dy_byte;
    logic [NUM_BTN-1:0] r_old;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [DX_W-1:0]    r_dx;
    logic [DY_W-1:0]    r_dy;
    logic [BTN_W-1:0]   r_btn;
    logic               r_last;

    logic               out_free;
    logic               can_emit;
    logic [PEND_W-1:0]  sel;
    logic [PEND_W-1:0]  rem;
    logic               load;
    logic [KIND_W-1:0]  ev_kind;
    logic [DX_W-1:0]    ev_dx;
    logic [DY_W-1:0]    ev_dy;
    logic [BTN_W-1:0]   ev_btn;

    assign out_free = !r_out_valid || o_out.ready;
    assign can_emit = (r_pending != '0) && out_free;
    assign sel      = r_pending & (~r_pending + PEND_W'(1));
    assign rem      = r_pending & ~sel;
    assign load     = i_q_stat.can_pop && ((r_pending == '0) || (can_emit && (rem == '0)));
    assign o_pop    = load;

    always_comb begin
        ev_kind = EV_MOVE;
        ev_dx   = '0;
        ev_dy   = '0;
        ev_btn  = '0;
        case (sel)
            4'b0001: begin
                ev_kind = EV_MOVE;
                ev_dx   = r_dx_byte;
                ev_dy   = DY_W'(0) - {r_dy_byte[BYTE_W-1], r_dy_byte};
            end
            4'b0010: begin
                ev_kind = r_old[0] ? EV_UP : EV_DOWN;
                ev_btn  = 2'd1;
            end
            4'b0100: begin
                ev_kind = r_old[1] ? EV_UP : EV_DOWN;
                ev_btn  = 2'd2;
            end
            4'b1000: begin
                ev_kind = r_old[2] ? EV_UP : EV_DOWN;
                ev_btn  = 2'd3;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_pending = r_pending;
        if (can_emit) begin
            n_pending = rem;
        end
        if (load) begin
            n_pending = {i_job.changed, i_job.has_move};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending <= n_pending;
            if (can_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dx_byte <= i_job.dx_byte;
            r_dy_byte <= i_job.dy_byte;
            r_old     <= i_job.old_buttons;
        end
        if (can_emit) begin
            r_kind <= ev_kind;
            r_dx   <= ev_dx;
            r_dy   <= ev_dy;
            r_btn  <= ev_btn;
            r_last <= (rem == '0);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_kind    = r_kind;
    assign o_out.delta_x       = r_dx;
    assign o_out.delta_y       = r_dy;
    assign o_out.button_number = r_btn;
    assign o_out.last_event    = r_last;

endmodule

[rtl/ps2_mouse_packet_decoder.sv]
// ============================================================================
// ps2_mouse_packet_decoder
// Path: the first event of a packet passes the job queue, pending and output
//   registers; its further events follow one per cycle while the sink is ready.
// Throughput: one input beat per cycle while the job queue has room; the back
//   part drains one event per cycle while the sink is ready, up to four per packet.
// Reset: synchronous active low; packet bytes and buttons clear, position 2.
// ============================================================================
module ps2_mouse_packet_decoder
    import pmd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmd_in_if.sink    i_in,
    pmd_out_if.source o_out
);

    // Front part: store bytes, track position and button state, and hand
    // each packet that causes events to the queue as one job.
    // Back part: pop jobs and emit move then button events in order, holding
    // a finished event in its output register while the sink stalls.

    t_q_stat q_stat;
    t_job    push_job;
    t_job    pop_job;
    logic    push;
    logic    pop;

    pmd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Queue decouples the two parts so each can stall on its own.
    pmd_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_stat  (q_stat)
    );

    pmd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_job    (pop_job),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

[tb/sv/ps2_mouse_packet_decoder_tb.sv]
// ============================================================================
// ps2_mouse_packet_decoder_tb
// Self-checking bench for the PS/2 mouse packet decoder. A short table of
// directed bytes covers reset alignment, the listener gate, the delta extremes
// and every button transition. Mostly well-formed random packets follow. A
// bit-accurate decoder model predicts events, except where a row gives its own;
// each output beat is compared field by field. Both channels idle at random.
// ============================================================================
module ps2_mouse_packet_decoder_tb;
    import pmd_pkg::*;

    // One mouse event as it leaves the output channel
    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic signed [DX_W-1:0] dx;
        logic signed [DY_W-1:0] dy;
        logic [BTN_W-1:0]       btn;
        logic                   last;
    } t_mouse_event;

    // Directed row: the byte to send plus an optional hand-written expectation
    // (typed = 1: use n_ev/ev instead of the model; n_ev is 0 or 1 event)
    typedef struct packed {
        logic         aux;
        logic [7:0]   data;
        logic         lis;
        logic         typed;
        logic         n_ev;
        t_mouse_event ev;
    } t_dir_row;

    localparam int NUM_DIR    = 22;
    localparam int NUM_RANDOM = 288;

    localparam t_mouse_event NO_EVENT = '0;

    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        // ignored beat: aux flag clear
        '{1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, NO_EVENT},
        // first byte after reset closes an all-zero packet: no events
        '{1'b1, 8'h00, 1'b1, 1'b1, 1'b0, NO_EVENT},
        // no listener: stored, position holds, then overwritten
        '{1'b1, 8'h07, 1'b0, 1'b1, 1'b0, NO_EVENT},
        '{1'b1, 8'h00, 1'b1, 1'b1, 1'b0, NO_EVENT},
        '{1'b1, 8'h7F, 1'b1, 1'b1, 1'b0, NO_EVENT},
        // largest dx, dy of -(-128) = 128, buttons unchanged
        '{1'b1, 8'h80, 1'b1, 1'b1, 1'b1,
          '{EV_MOVE, 8'sd127, 9'sd128, 2'd0, 1'b1}},
        // most negative dx, all three buttons down
        '{1'b1, 8'h07, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'h80, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'h7F, 1'b1, 1'b0, 1'b0, NO_EVENT},
        // all buttons up, no motion
        '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, NO_EVENT},
        // dy only, buttons 1 and 3 down
        '{1'b1, 8'h05, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'h01, 1'b1, 1'b0, 1'b0, NO_EVENT},
        // mixed directions, upper status bits set
        '{1'b1, 8'hFA, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, NO_EVENT},
        // ignored beat mid-stream with no listener either
        '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, NO_EVENT},
        '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'h01, 1'b1, 1'b0, 1'b0, NO_EVENT},
        '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, NO_EVENT}
    };

    logic i_clk;
    logic i_rst_n;

    pmd_in_if  in_if ();
    pmd_out_if out_if ();

    ps2_mouse_packet_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Decoder model state
    logic [7:0]         pkt_bytes [3];
    logic [POS_W-1:0]   cur_pos;
    logic [NUM_BTN-1:0] btn_state;

    t_mouse_event fresh_events [$];   // events caused by the latest byte
    t_mouse_event pending_events [$]; // events still owed by the block

    int  mismatch_count = 0;
    int  stall_left     = 0;
    logic tx_calm       = 1'b0;       // sender runs without gaps
    logic rx_calm       = 1'b0;       // receiver runs without stalls

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("ps2_mouse_packet_decoder verification failed");
        $finish;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Byte values skewed toward zero and the signed extremes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'h00;
        if (r < 28) begin
            case ($urandom_range(0, 3))
                0:       return 8'h80;
                1:       return 8'h7F;
                2:       return 8'hFF;
                default: return 8'h01;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Model one accepted byte; leave its events in fresh_events
    task automatic decode_mouse_byte(input logic aux, input logic [7:0] data,
                                     input logic lis);
        logic [POS_W-1:0] pos;
        t_mouse_event     ev_buf [4];
        int               n;
        fresh_events.delete();
        n = 0;
        if (!aux)
            return;
        // position three would wrap to the first byte
        pos = (cur_pos == POS_BAD) ? POS_FIRST : cur_pos;
        pkt_bytes[pos] = data;
        if (!lis) begin
            cur_pos = pos;
            return;
        end
        pos = (pos == POS_LAST) ? POS_FIRST : pos + 1'b1;
        cur_pos = pos;
        if (pos != POS_FIRST)
            return;
        if (pkt_bytes[1] != 8'h00 || pkt_bytes[2] != 8'h00) begin
            ev_buf[n]      = '0;
            ev_buf[n].kind = EV_MOVE;
            ev_buf[n].dx   = pkt_bytes[1];
            // negate the sign-extended byte in nine bits
            ev_buf[n].dy   = 9'd0 - {pkt_bytes[2][7], pkt_bytes[2]};
            n++;
        end
        for (int i = 0; i < NUM_BTN; i++) begin
            if (pkt_bytes[0][i] != btn_state[i]) begin
                ev_buf[n]      = '0;
                ev_buf[n].kind = btn_state[i] ? EV_UP : EV_DOWN;
                ev_buf[n].btn  = BTN_W'(i + 1);
                n++;
            end
        end
        btn_state = pkt_bytes[0][NUM_BTN-1:0];
        if (n > 0)
            ev_buf[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            fresh_events.push_back(ev_buf[i]);
    endtask

    // Drive one byte after a random gap; return at the edge that accepts it
    task automatic send_byte(input logic aux, input logic [7:0] data, input logic lis);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid            <= 1'b1;
        in_if.aux_ready        <= aux;
        in_if.data_byte        <= data;
        in_if.listener_present <= lis;
        do
            @(posedge i_clk);
        while (!in_if.ready);
    endtask

    // Output side: check each accepted beat, then pick next cycle's ready
    always @(posedge i_clk) begin
        t_mouse_event want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected event: kind %0d button %0d",
                           out_if.event_kind, out_if.button_number);
                    mismatch_count++;
                end else begin
                    want = pending_events.pop_front();
                    if (out_if.event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, got %0d", want.kind,
                               out_if.event_kind);
                        mismatch_count++;
                    end
                    if (out_if.delta_x !== want.dx) begin
                        $error("delta_x: expected %0d, got %0d", want.dx, out_if.delta_x);
                        mismatch_count++;
                    end
                    if (out_if.delta_y !== want.dy) begin
                        $error("delta_y: expected %0d, got %0d", want.dy, out_if.delta_y);
                        mismatch_count++;
                    end
                    if (out_if.button_number !== want.btn) begin
                        $error("button_number: expected %0d, got %0d", want.btn,
                               out_if.button_number);
                        mismatch_count++;
                    end
                    if (out_if.last_event !== want.last) begin
                        $error("last_event: expected %0d, got %0d", want.last,
                               out_if.last_event);
                        mismatch_count++;
                    end
                end
            end
            // hold ready low through a stall, otherwise maybe start one
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap(1'b0);
            end
        end else begin
            out_if.ready <= 1'b0;
        end
    end

    initial begin
        logic       aux;
        logic       lis;
        logic [7:0] data;
        int         sent;
        int         r;

        // clear the model to its reset state
        pkt_bytes[0] = 8'h00;
        pkt_bytes[1] = 8'h00;
        pkt_bytes[2] = 8'h00;
        cur_pos      = POS_LAST;
        btn_state    = '0;

        i_rst_n                <= 1'b0;
        in_if.valid            <= 1'b0;
        in_if.aux_ready        <= 1'b0;
        in_if.data_byte        <= 8'h00;
        in_if.listener_present <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int k = 0; k < NUM_DIR; k++) begin
            send_byte(DIR_ROWS[k].aux, DIR_ROWS[k].data, DIR_ROWS[k].lis);
            decode_mouse_byte(DIR_ROWS[k].aux, DIR_ROWS[k].data, DIR_ROWS[k].lis);
            if (DIR_ROWS[k].typed) begin
                if (DIR_ROWS[k].n_ev)
                    pending_events.push_back(DIR_ROWS[k].ev);
            end else begin
                foreach (fresh_events[j])
                    pending_events.push_back(fresh_events[j]);
            end
        end

        // Random part: mostly listened-to bytes, some unheard, some ignored
        sent = 0;
        while (sent < NUM_RANDOM) begin
            if (sent % 40 == 0) begin
                tx_calm = ($urandom_range(0, 99) < 25);
                rx_calm = ($urandom_range(0, 99) < 25);
            end
            r    = $urandom_range(0, 99);
            aux  = (r >= 8);
            lis  = (r < 8) ? 1'($urandom_range(0, 1)) : (r >= 15);
            data = pick_byte();
            send_byte(aux, data, lis);
            decode_mouse_byte(aux, data, lis);
            foreach (fresh_events[j])
                pending_events.push_back(fresh_events[j]);
            sent++;
        end
        in_if.valid <= 1'b0;

        // drain, then keep watching for stray events
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("ps2_mouse_packet_decoder verification clean");
        else
            $display("ps2_mouse_packet_decoder verification failed");
        $finish;
    end

endmodule
